// File: hw/rtl/srsw_pkg.sv
// Shared constants, types and state codes of the selective-repeat sender window.
package srsw_pkg;

    // Sequence space and window limits
    localparam int SEQ_SPACE  = 1024;
    localparam int MAX_WINDOW = 8;

    // Field widths fixed by the interface
    localparam int REQ_SEQ_W   = 10;
    localparam int SEND_SEQ_W  = 10;
    localparam int WIN_SIZE_W  = 4;
    localparam int MSG_COUNT_W = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 1;

    // Derived widths
    localparam int SEQ_W  = $clog2(SEQ_SPACE);
    localparam int BASE_W = SEQ_W + 1;
    localparam int SUM_W  = BASE_W + 1;
    localparam int IDX_W  = $clog2(MAX_WINDOW + 1);

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Request type codes
    localparam logic REQ_ACK   = 1'b0;
    localparam logic REQ_ROUND = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_COUNT = 1'd1;

    // Configuration reset values
    localparam logic [WIN_SIZE_W-1:0]  WINDOW_SIZE_RST   = 4'd4;
    localparam logic [MSG_COUNT_W-1:0] MESSAGE_COUNT_RST = 11'd201;

    // Classified request handed from front to back
    typedef struct packed {
        logic             is_round;
        logic             ack_ok;
        logic [SEQ_W-1:0] ack_addr;
    } srsw_cmd_t;

    // Live configuration seen by the back end
    typedef struct packed {
        logic [WIN_SIZE_W-1:0]  window_size;
        logic [MSG_COUNT_W-1:0] message_count;
    } srsw_cfg_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_RND_RD,
        ST_RND_CHK,
        ST_RND_END
    } srsw_state_t;

endpackage

// File: hw/rtl/srsw_req_if.sv
// Request channel: valid/ready handshake with request type and ack sequence number.
interface srsw_req_if import srsw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [REQ_SEQ_W-1:0] ack_seq;

    modport source (output valid, output req_type, output ack_seq, input ready);
    modport sink   (input valid, input req_type, input ack_seq, output ready);
endinterface

// File: hw/rtl/srsw_res_if.sv
// Result channel: valid/ready handshake with sequence number to send and round-end flag.
interface srsw_res_if import srsw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [SEND_SEQ_W-1:0] send_seq;
    logic                  last_of_round;

    modport source (output valid, output send_seq, output last_of_round, input ready);
    modport sink   (input valid, input send_seq, input last_of_round, output ready);
endinterface

// File: hw/rtl/srsw_front.sv
// Front end: takes requests, classifies them and pushes commands into the queue.
module srsw_front import srsw_pkg::*; (
    srsw_req_if.sink  req,
    input  logic      clearing,
    input  logic      q_full,
    output logic      q_push,
    output srsw_cmd_t q_cmd
);

    // Hold off requests while the map is being cleared or the queue is full
    assign req.ready = !clearing && !q_full;
    assign q_push    = req.valid && req.ready;

    // Classify: send round or ack, and check that the ack lands in the store
    always_comb
    begin
        q_cmd.is_round = (req.req_type == REQ_ROUND);
        q_cmd.ack_ok   = (req.req_type == REQ_ACK) && (32'(req.ack_seq) < SEQ_SPACE);
        q_cmd.ack_addr = SEQ_W'(req.ack_seq);
    end

endmodule

// File: hw/rtl/srsw_cmd_fifo.sv
// Short command queue decoupling the front end from the back end.
module srsw_cmd_fifo import srsw_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  srsw_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output srsw_cmd_t pop_cmd
);

    srsw_cmd_t             entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hw/rtl/srsw_back.sv
// Back end: ack bitmap memory, window base advance and send-round sequencer.
module srsw_back import srsw_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  srsw_cfg_t  cfg,
    input  logic       cmd_valid,
    input  srsw_cmd_t  cmd,
    output logic       cmd_pop,
    output logic       clearing,
    srsw_res_if.source res
);

    // Ack bitmap memory
    logic                  map_mem [SEQ_SPACE];
    logic                  map_we;
    logic [SEQ_W-1:0]      map_waddr;
    logic                  map_wdata;
    logic                  rd_en;
    logic [SEQ_W-1:0]      rd_addr;
    logic                  rd_data_reg;

    srsw_state_t           state_reg, state_next;
    logic [BASE_W-1:0]     base_reg, base_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [SEQ_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [SEQ_W-1:0]      pend_seq_reg, pend_seq_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SEND_SEQ_W-1:0] out_seq_reg, out_seq_next;
    logic                  out_last_reg, out_last_next;

    logic [BASE_W-1:0]     lim;
    logic [IDX_W-1:0]      win;
    logic [SUM_W-1:0]      seq_sum;
    logic [BASE_W-1:0]     base_inc;
    logic                  slot_free;
    logic                  emit;
    logic                  emit_last;

    // Effective send limit and window width
    assign lim      = (32'(cfg.message_count) > SEQ_SPACE) ? BASE_W'(SEQ_SPACE)
                                                           : BASE_W'(cfg.message_count);
    assign win      = (32'(cfg.window_size) > MAX_WINDOW) ? IDX_W'(MAX_WINDOW)
                                                          : IDX_W'(cfg.window_size);
    assign seq_sum  = SUM_W'(base_reg) + SUM_W'(idx_reg);
    assign base_inc = base_reg + 1'b1;

    assign slot_free = !out_valid_reg || res.ready;
    assign clearing  = (state_reg == ST_CLEAR);

    assign res.valid         = out_valid_reg;
    assign res.send_seq      = out_seq_reg;
    assign res.last_of_round = out_last_reg;

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        idx_next        = idx_reg;
        clr_cnt_next    = clr_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_seq_next   = pend_seq_reg;
        map_we          = 1'b0;
        map_waddr       = clr_cnt_reg;
        map_wdata       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = base_reg[SEQ_W-1:0];
        cmd_pop         = 1'b0;
        emit            = 1'b0;
        emit_last       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                map_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SEQ_W'(SEQ_SPACE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.is_round)
                    begin
                        idx_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_RND_RD;
                    end
                    else
                    begin
                        map_we     = cmd.ack_ok;
                        map_waddr  = cmd.ack_addr;
                        map_wdata  = 1'b1;
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                if (base_reg < lim)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_SCAN_CHK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_CHK:
            begin
                // One entry per cycle: on a set bit, step base and read the next one
                if (rd_data_reg)
                begin
                    base_next = base_inc;
                    if (base_inc < lim)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = base_inc[SEQ_W-1:0];
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RND_RD:
            begin
                if ((idx_reg < win) && (seq_sum < SUM_W'(lim)))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = seq_sum[SEQ_W-1:0];
                    state_next = ST_RND_CHK;
                end
                else
                begin
                    state_next = ST_RND_END;
                end
            end
            ST_RND_CHK:
            begin
                // Hold one found entry back so the round's last can be flagged
                if (rd_data_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RND_RD;
                end
                else if (!pend_valid_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_seq_next   = seq_sum[SEQ_W-1:0];
                    idx_next        = idx_reg + 1'b1;
                    state_next      = ST_RND_RD;
                end
                else if (slot_free)
                begin
                    emit          = 1'b1;
                    pend_seq_next = seq_sum[SEQ_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                    state_next    = ST_RND_RD;
                end
            end
            ST_RND_END:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    emit            = 1'b1;
                    emit_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_seq_next   = out_seq_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_seq_next   = SEND_SEQ_W'(pend_seq_reg);
            out_last_next  = emit_last;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            base_reg       <= '0;
            idx_reg        <= '0;
            clr_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            idx_reg        <= idx_next;
            clr_cnt_reg    <= clr_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_seq_reg <= pend_seq_next;
        out_seq_reg  <= out_seq_next;
        out_last_reg <= out_last_next;
    end

    // Bitmap memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // Base moves only while scanning, one step at a time
    a_base_step: assert property (@(posedge clk) disable iff (!rst_n)
        (base_reg != $past(base_reg)) |->
            ($past(state_reg) == ST_SCAN_CHK && base_reg == $past(base_reg) + 1'b1))
        else $error("window base moved outside the scan or by more than one");

    // Base never runs past the store
    a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg <= BASE_W'(SEQ_SPACE))
        else $error("window base beyond sequence space");

    // No command is taken while the clearing pass runs
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !cmd_pop)
        else $error("command popped during clearing pass");

    // Results come only from a held entry during a round
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (pend_valid_reg && (state_reg == ST_RND_CHK || state_reg == ST_RND_END)))
        else $error("result emitted without a held entry");

    // Bitmap is written only by the clearing pass or an ack
    a_map_write: assert property (@(posedge clk) disable iff (!rst_n)
        map_we |-> (state_reg == ST_CLEAR || state_reg == ST_IDLE))
        else $error("bitmap written outside clear or ack");

endmodule

// File: hw/rtl/selective_repeat_sender_window.sv
// Flow: an accepted ack passes through the command queue; the back end then writes its bit
// and scans the base forward over acked entries. A send round takes the request, reads and
// checks each entry (up to the window size) and flushes the last result at round end.
// Only one request at a time is handled in the back end, set by the bitmap read loop;
// results leave through a registered output stage, and a stalled output holds the round.
// Reset: base and config reset; a clearing pass zeroes the bitmap, req.ready low.
module selective_repeat_sender_window import srsw_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    srsw_req_if.sink              req,
    srsw_res_if.source            res
);

    logic [WIN_SIZE_W-1:0]  window_size_reg, window_size_next;
    logic [MSG_COUNT_W-1:0] message_count_reg, message_count_next;
    srsw_cfg_t              cfg;

    logic      clearing;
    logic      q_full;
    logic      q_push;
    srsw_cmd_t q_push_cmd;
    logic      q_pop;
    logic      q_valid;
    srsw_cmd_t q_pop_cmd;

    // Configuration register writes
    always_comb
    begin
        window_size_next   = window_size_reg;
        message_count_next = message_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_SIZE:   window_size_next   = cfg_data[WIN_SIZE_W-1:0];
                CFG_MESSAGE_COUNT: message_count_next = cfg_data[MSG_COUNT_W-1:0];
                default:           window_size_next   = window_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg   <= WINDOW_SIZE_RST;
            message_count_reg <= MESSAGE_COUNT_RST;
        end
        else
        begin
            window_size_reg   <= window_size_next;
            message_count_reg <= message_count_next;
        end
    end

    assign cfg.window_size   = window_size_reg;
    assign cfg.message_count = message_count_reg;

    // Front end: request intake and classification
    srsw_front u_front (
        .req      (req),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd)
    );

    // Command queue
    srsw_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (q_pop_cmd)
    );

    // Back end: bitmap, base advance and send rounds
    srsw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (q_valid),
        .cmd       (q_pop_cmd),
        .cmd_pop   (q_pop),
        .clearing  (clearing),
        .res       (res)
    );

endmodule
